// ===== sv/coding_access_lockout_fsm_macros.svh =====
// Assertion macros for the coding access lockout RTL.
`ifndef CODING_ACCESS_LOCKOUT_FSM_MACROS_SVH
`define CODING_ACCESS_LOCKOUT_FSM_MACROS_SVH

// Next-cycle implication, checked outside reset.
`define CAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define CAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/cal_pkg.sv =====
// Types and constants shared by the coding access lockout block.
`timescale 1ns / 1ps

package cal_pkg;

    localparam logic [14:0] LOCKOUT_CAP    = 15'd30000;
    localparam logic [7:0]  VALUE_WILDCARD = 8'hFF;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TICKS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INHIBIT_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_INDEX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MAX      = 3'd4;

    typedef enum logic [2:0] {
        ACC_NONE    = 3'd0,
        ACC_REQ_OK  = 3'd1,
        ACC_REMOTE  = 3'd2,
        ACC_REFUSED = 3'd3,
        ACC_PROGRAM = 3'd4
    } t_access;

    typedef struct packed {
        logic [14:0] lockout_load;
        logic        inhibit_first;
        logic [7:0]  expected_index;
        logic [7:0]  value_min;
        logic [7:0]  value_max;
    } t_cfg;

    // declared high field first so the last field lands in the low bits
    typedef struct packed {
        logic       write_checked;
        logic       service_mode;
        logic       main_wakeup;
        logic [7:0] record_value;
        logic [7:0] record_index;
        logic [2:0] access_status;
    } t_in_item;

    typedef struct packed {
        logic        save_lockout;
        logic        save_record;
        logic        coding_done;
        logic [7:0]  stored_value;
        logic [7:0]  stored_index;
        logic [14:0] ticks_left;
        logic        lockout_flag;
        logic        record_valid;
        logic [2:0]  status;
    } t_result;

    localparam int IN_BITS    = $bits(t_in_item);
    localparam int OUT_BITS   = $bits(t_result);
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ===== sv/cal_cfg.sv =====
// Configuration register file; the lockout length is clamped when written.
`timescale 1ns / 1ps

module cal_cfg
    import cal_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_load   <= '0;
            r_cfg.inhibit_first  <= 1'b0;
            r_cfg.expected_index <= '0;
            r_cfg.value_min      <= '0;
            r_cfg.value_max      <= 8'hFF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LOCKOUT_TICKS: begin
                    if (i_cfg_data < {1'b0, LOCKOUT_CAP}) begin
                        r_cfg.lockout_load <= i_cfg_data[14:0];
                    end else begin
                        r_cfg.lockout_load <= LOCKOUT_CAP;
                    end
                end
                REG_INHIBIT_FIRST:  r_cfg.inhibit_first  <= i_cfg_data[0];
                REG_EXPECTED_INDEX: r_cfg.expected_index <= i_cfg_data[7:0];
                REG_VALUE_MIN:      r_cfg.value_min      <= i_cfg_data[7:0];
                REG_VALUE_MAX:      r_cfg.value_max      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/cal_core.sv =====
// Record check, access state machine, lockout countdown and latched record.
`timescale 1ns / 1ps

module cal_core
    import cal_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_beat,
    input  logic     i_restore,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_LOCKOUT     = 3'd1,
        ST_NEED_ACCESS = 3'd2,
        ST_SEED        = 3'd3,
        ST_WAIT        = 3'd4,
        ST_DATA_BAD    = 3'd5,
        ST_WRITE       = 3'd6
    } t_state;

    t_state      r_state,       n_state;
    logic        r_lock_active, n_lock_active;
    logic [14:0] r_lock_cnt,    n_lock_cnt;
    logic        r_done,        n_done;
    logic [7:0]  r_lat_index,   n_lat_index;
    logic [7:0]  r_lat_value,   n_lat_value;
    logic        n_save_rec, n_save_lock;
    logic        w_valid;
    logic        w_in_range;
    logic [2:0]  w_acc;

    assign w_acc      = i_item.access_status;
    assign w_in_range = (i_item.record_value >= i_cfg.value_min) &&
                        (i_item.record_value <= i_cfg.value_max);
    assign w_valid    = (i_item.record_index == i_cfg.expected_index) &&
                        (w_in_range || (i_item.record_value == VALUE_WILDCARD));

    always_comb begin
        n_state       = r_state;
        n_lock_active = r_lock_active;
        n_lock_cnt    = r_lock_cnt;
        n_done        = r_done;
        n_lat_index   = r_lat_index;
        n_lat_value   = r_lat_value;
        n_save_rec    = 1'b0;
        n_save_lock   = 1'b0;
        if (i_restore) begin
            n_lat_index = '0;
            n_lat_value = 8'hFF;
            n_done      = 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (r_lock_active) begin
                        n_lock_active = 1'b1;
                        n_save_lock   = 1'b1;
                        n_state       = ST_LOCKOUT;
                        n_lock_cnt    = i_cfg.lockout_load;
                    end else if (!r_done && !i_cfg.inhibit_first) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_state = ST_NEED_ACCESS;
                    end
                end
                ST_NEED_ACCESS: begin
                    if (w_acc == ACC_REQ_OK) begin
                        n_state = ST_SEED;
                    end else if (w_acc == ACC_REMOTE) begin
                        n_state = ST_WAIT;
                    end
                end
                ST_LOCKOUT: begin
                    if (r_lock_cnt == '0) begin
                        n_lock_active = 1'b0;
                        n_state       = ST_IDLE;
                    end else begin
                        n_lock_cnt = r_lock_cnt - 15'd1;
                    end
                end
                ST_SEED: begin
                    if ((r_lock_active && w_acc != ACC_REMOTE) || w_acc == ACC_REFUSED) begin
                        n_lock_active = 1'b1;
                        n_save_lock   = 1'b1;
                        n_state       = ST_LOCKOUT;
                        n_lock_cnt    = i_cfg.lockout_load;
                    end else if (w_acc == ACC_REMOTE) begin
                        n_state = ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_acc == ACC_PROGRAM) begin
                        n_state = w_valid ? ST_WRITE : ST_DATA_BAD;
                    end else if (!i_item.main_wakeup || !i_item.service_mode ||
                                 (w_acc != ACC_REMOTE && (r_done || i_cfg.inhibit_first))) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_DATA_BAD, ST_WRITE: begin
                    if (i_item.write_checked) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
            // first entry into write latches the record
            if (n_state == ST_WRITE && r_state != ST_WRITE) begin
                n_lat_index = i_item.record_index;
                n_lat_value = i_item.record_value;
                n_done      = 1'b1;
                n_save_rec  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_lock_active <= 1'b0;
            r_lock_cnt    <= '0;
            r_done        <= 1'b0;
            r_lat_index   <= '0;
            r_lat_value   <= 8'hFF;
        end else if (i_beat) begin
            r_state       <= n_state;
            r_lock_active <= n_lock_active;
            r_lock_cnt    <= n_lock_cnt;
            r_done        <= n_done;
            r_lat_index   <= n_lat_index;
            r_lat_value   <= n_lat_value;
        end
    end

    always_comb begin
        o_result.status       = n_state;
        o_result.record_valid = w_valid;
        o_result.lockout_flag = n_lock_active;
        o_result.ticks_left   = n_lock_cnt;
        o_result.stored_index = n_lat_index;
        o_result.stored_value = n_lat_value;
        o_result.coding_done  = n_done;
        o_result.save_record  = n_save_rec;
        o_result.save_lockout = n_save_lock;
    end

`include "coding_access_lockout_fsm_macros.svh"

    `CAL_ASSERT_NOW(a_lockout_flag, i_clk, i_rst_n, r_state == ST_LOCKOUT, r_lock_active, "lockout state without lockout flag")
    `CAL_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_lock_cnt <= LOCKOUT_CAP, "lockout count above cap")
    `CAL_ASSERT_NEXT(a_save_rec, i_clk, i_rst_n, i_beat && n_save_rec, r_state == ST_WRITE && r_done, "record saved outside write")
    `CAL_ASSERT_NEXT(a_countdown, i_clk, i_rst_n, i_beat && !i_restore && r_state == ST_LOCKOUT && r_lock_cnt != '0, r_lock_cnt == $past(r_lock_cnt) - 15'd1, "lockout count did not step down")

endmodule

// ===== sv/cal_skid.sv =====
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps

module cal_skid
    import cal_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main       <= i_data;
                r_main_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// ===== sv/coding_access_lockout_fsm.sv =====
// Coding access gate with anti-scanning lockout: top level.
//
// Input stream: one beat per periodic tick. tuser carries the command
// (0 step, 1 restore defaults); tdata carries the access status, the
// two-byte record and the wakeup, service and write-checked flags.
// Output stream: one result beat per input beat, in order, with the state,
// record check, lockout flag and count, latched record, done flag and the
// two save strobes.
// Config port: registers written by index; the user writes only while idle
// (not enforced by the block); the lockout length is clamped to 30000 on write.
// Results are registered: result register, or skid register during a stall.
// Throughput: one beat per cycle while tready is high; the state update is
// combinational logic between the state registers and the output register.
// Reset: state idle, lockout cleared, latched value 255, output empty.
// Stall: a result register and a skid register absorb one extra beat;
// input tready drops only while both are full.
`timescale 1ns / 1ps

module coding_access_lockout_fsm
    import cal_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // access_status[2:0], record_index[10:3], record_value[18:11],
    // main_wakeup[19], service_mode[20], write_checked[21]
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // command[0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[2:0], record_valid[3], lockout_flag[4], ticks_left[19:5],
    // stored_index[27:20], stored_value[35:28], coding_done[36],
    // save_record[37], save_lockout[38]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    t_cfg     w_cfg;
    t_in_item w_item;
    t_result  w_result;
    t_result  w_out;
    logic     w_beat;

    assign w_item = t_in_item'(i_s_axis_tdata[IN_BITS-1:0]);
    assign w_beat = i_s_axis_tvalid && o_s_axis_tready;

    cal_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cal_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .i_restore (i_s_axis_tuser),
        .i_item    (w_item),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    cal_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (w_result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, w_out};

endmodule
